FILE: rtl/imlp_pkg.sv
package imlp_pkg;

  // Default sizes of the network.
  localparam int FEATURES_DEF = 64;
  localparam int HIDDEN_DEF   = 32;
  localparam int CLASSES_DEF  = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 20'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1_WSCALE = 2'd0,
    REG_L1_BSCALE = 2'd1,
    REG_L2_WSCALE = 2'd2,
    REG_L2_BSCALE = 2'd3
  } cfg_reg_e;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    FUNC_LOAD_W1   = 3'd0,
    FUNC_LOAD_B1   = 3'd1,
    FUNC_LOAD_W2   = 3'd2,
    FUNC_LOAD_B2   = 3'd3,
    FUNC_LOAD_NORM = 3'd4,
    FUNC_FEATURE   = 3'd5
  } func_e;

  // Softmax widths: exp values are Q1.16, the sum covers up to 64 classes.
  localparam int EXP_W = 17;
  localparam int SUM_W = 23;
  localparam int PROB_W = 16;

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         row;
    logic [6:0]         col;
    logic signed [7:0]  quant_value;
    logic signed [15:0] norm_mean;
    logic [15:0]        norm_recip;
    logic signed [15:0] feature_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  class_index;
    logic [15:0] probability;
    logic [5:0]  best_class;
    logic        last;
  } out_item_t;

  typedef logic [EXP_W-1:0] exp_tab_t [256];

  // exp(-k/16) in Q1.16, built by repeated rounded multiplication in Q32.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [95:0] p;
    t = 64'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      if (k > 0) begin
        p = 96'(t) * 96'd4034748382 + (96'd1 << 31);
        t = p[95:32];
      end
      tab[k] = EXP_W'((t + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

FILE: rtl/int8_mlp_classifier.sv
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_ready   | in_data (loads and features)
// out      | output    | out_valid / out_ready | out_data (one per class)
// cfg      | input     | cfg_we                | cfg_index, cfg_data
//
// A load item or a non-final feature leaves the block idle; it is ready again next cycle.
// The final feature starts an inference that runs on the single multiply-accumulate
// pipeline and the bit-serial divider.
// Results leave through one output register; the next is loaded after the last transfers.
// in_ready is low from the final feature until the last result transfers.
// Synchronous reset clears the control state and sets every scale to 1.0.
module int8_mlp_classifier #(
  parameter int FEATURES     = imlp_pkg::FEATURES_DEF,
  parameter int HIDDEN_UNITS = imlp_pkg::HIDDEN_DEF,
  parameter int CLASSES      = imlp_pkg::CLASSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  imlp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output imlp_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [imlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import imlp_pkg::*;

  localparam int F_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int H_W   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int C_W   = $clog2(CLASSES);
  localparam int I_W   = (F_W > H_W) ? F_W : H_W;
  localparam int J_W   = (H_W > C_W) ? H_W : C_W;
  localparam int FC_W  = $clog2(FEATURES + 1);
  localparam int W1_N  = FEATURES * HIDDEN_UNITS;
  localparam int W2_N  = HIDDEN_UNITS * CLASSES;
  localparam int W1_AW = (W1_N > 1) ? $clog2(W1_N) : 1;
  localparam int W2_AW = $clog2(W2_N);

  localparam logic signed [47:0] ACC2_MAX = (48'sd1 <<< 42) - 48'sd1;
  localparam logic signed [47:0] ACC2_MIN = -(48'sd1 <<< 42);
  localparam logic signed [64:0] I32_MAX  = 65'sd2147483647;
  localparam logic signed [64:0] I32_MIN  = -65'sd2147483648;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_RUN      = 13'b0000000000010,
    S_DRAIN    = 13'b0000000000100,
    S_SCALE    = 13'b0000000001000,
    S_STORE    = 13'b0000000010000,
    S_MAX      = 13'b0000000100000,
    S_EXP      = 13'b0000001000000,
    S_DIV_RD   = 13'b0000010000000,
    S_DIV_GO   = 13'b0000100000000,
    S_DIV_WAIT = 13'b0001000000000,
    S_OUT_RD   = 13'b0010000000000,
    S_OUT_LD   = 13'b0100000000000,
    S_OUT_WAIT = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] l1_wscale, l1_bscale, l2_wscale, l2_bscale;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_wscale <= SCALE_RESET;
      l1_bscale <= SCALE_RESET;
      l2_wscale <= SCALE_RESET;
      l2_bscale <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_L1_WSCALE: l1_wscale <= cfg_data;
        REG_L1_BSCALE: l1_bscale <= cfg_data;
        REG_L2_WSCALE: l2_wscale <= cfg_data;
        REG_L2_BSCALE: l2_bscale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parameter and activation memories.
  logic signed [7:0]  w1_mem   [0:W1_N-1];
  logic signed [7:0]  b1_mem   [0:HIDDEN_UNITS-1];
  logic signed [7:0]  w2_mem   [0:W2_N-1];
  logic signed [7:0]  b2_mem   [0:CLASSES-1];
  logic signed [15:0] mean_mem [0:FEATURES-1];
  logic [15:0]        rcp_mem  [0:FEATURES-1];
  logic signed [15:0] feat_mem [0:FEATURES-1];
  logic signed [31:0] hid_mem  [0:HIDDEN_UNITS-1];
  logic signed [31:0] lgt_mem  [0:CLASSES-1];
  logic [EXP_W-1:0]   e_mem    [0:CLASSES-1];
  logic [PROB_W-1:0]  p_mem    [0:CLASSES-1];

  logic signed [7:0]  w1_rd, b1_rd, w2_rd, b2_rd;
  logic signed [15:0] mean_rd, feat_rd;
  logic [15:0]        rcp_rd;
  logic signed [31:0] hid_rd, lgt_rd;
  logic [EXP_W-1:0]   e_rd;
  logic [PROB_W-1:0]  p_rd;

  // Sequencer counters.
  logic [I_W-1:0]  i;
  logic [J_W-1:0]  j;
  logic [C_W-1:0]  k;
  logic [FC_W-1:0] fc;
  logic            layer;
  logic            i_last, j_last, k_last;

  logic            in_xfer;
  logic [W1_AW-1:0] w1_ld_addr, w1_rd_addr;
  logic [W2_AW-1:0] w2_ld_addr, w2_rd_addr;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign i_last = layer ? (i == I_W'(HIDDEN_UNITS - 1)) : (i == I_W'(FEATURES - 1));
  assign j_last = layer ? (j == J_W'(CLASSES - 1)) : (j == J_W'(HIDDEN_UNITS - 1));
  assign k_last = (k == C_W'(CLASSES - 1));

  assign w1_ld_addr = W1_AW'(in_data.row[F_W-1:0]) * W1_AW'(HIDDEN_UNITS)
                    + W1_AW'(in_data.col[H_W-1:0]);
  assign w2_ld_addr = W2_AW'(in_data.row[H_W-1:0]) * W2_AW'(CLASSES)
                    + W2_AW'(in_data.col[C_W-1:0]);
  assign w1_rd_addr = W1_AW'(i[F_W-1:0]) * W1_AW'(HIDDEN_UNITS) + W1_AW'(j[H_W-1:0]);
  assign w2_rd_addr = W2_AW'(i[H_W-1:0]) * W2_AW'(CLASSES) + W2_AW'(j[C_W-1:0]);

  // Table loads and feature writes, taken while idle.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      case (in_data.func)
        FUNC_LOAD_W1: begin
          if (32'(in_data.row) < FEATURES && 32'(in_data.col) < HIDDEN_UNITS) begin
            w1_mem[w1_ld_addr] <= in_data.quant_value;
          end
        end
        FUNC_LOAD_B1: begin
          if (32'(in_data.col) < HIDDEN_UNITS) begin
            b1_mem[in_data.col[H_W-1:0]] <= in_data.quant_value;
          end
        end
        FUNC_LOAD_W2: begin
          if (32'(in_data.row) < HIDDEN_UNITS && 32'(in_data.col) < CLASSES) begin
            w2_mem[w2_ld_addr] <= in_data.quant_value;
          end
        end
        FUNC_LOAD_B2: begin
          if (32'(in_data.col) < CLASSES) begin
            b2_mem[in_data.col[C_W-1:0]] <= in_data.quant_value;
          end
        end
        FUNC_LOAD_NORM: begin
          if (32'(in_data.row) < FEATURES) begin
            mean_mem[in_data.row[F_W-1:0]] <= in_data.norm_mean;
            rcp_mem[in_data.row[F_W-1:0]]  <= in_data.norm_recip;
          end
        end
        FUNC_FEATURE: begin
          feat_mem[fc[F_W-1:0]] <= in_data.feature_value;
        end
        default: ;
      endcase
    end
  end

  // Registered reads, each memory at one sequencer address.
  always_ff @(posedge clk) begin
    w1_rd   <= w1_mem[w1_rd_addr];
    w2_rd   <= w2_mem[w2_rd_addr];
    mean_rd <= mean_mem[i[F_W-1:0]];
    rcp_rd  <= rcp_mem[i[F_W-1:0]];
    feat_rd <= feat_mem[i[F_W-1:0]];
    hid_rd  <= hid_mem[i[H_W-1:0]];
    b1_rd   <= b1_mem[j[H_W-1:0]];
    b2_rd   <= b2_mem[j[C_W-1:0]];
    lgt_rd  <= lgt_mem[k];
    e_rd    <= e_mem[k];
    p_rd    <= p_mem[k];
  end

  // Multiply-accumulate pipeline: read, normalize, multiply, accumulate.
  logic               v1, v2, v3, first1, first2, first3, last1, last2, last3;
  logic signed [16:0] diff, rcp_eff;
  logic signed [33:0] norm_prod, norm_sh;
  logic signed [31:0] xval;
  logic signed [7:0]  wd;
  logic signed [39:0] mac_prod;
  logic signed [47:0] acc;
  logic               acc_done;

  always_comb begin
    diff      = 17'(feat_rd) - 17'(mean_rd);
    rcp_eff   = (rcp_rd == '0) ? 17'sd4096 : signed'({1'b0, rcp_rd});
    norm_prod = diff * rcp_eff;
    norm_sh   = norm_prod >>> 12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
      v3 <= v2;
      if (v3 && last3) begin
        acc_done <= 1'b1;
      end else if (state == S_DRAIN) begin
        acc_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first1   <= (i == '0);
    last1    <= i_last;
    first2   <= first1;
    last2    <= last1;
    first3   <= first2;
    last3    <= last2;
    xval     <= layer ? hid_rd : 32'(norm_sh);
    wd       <= layer ? w2_rd : w1_rd;
    mac_prod <= xval * wd;
    if (v3) begin
      acc <= first3 ? 48'(mac_prod) : acc + 48'(mac_prod);
    end
  end

  // Dequantization of one finished neuron.
  logic signed [42:0] acc_op;
  logic signed [63:0] mprod, msh;
  logic signed [28:0] bprod;
  logic signed [64:0] tot;
  logic signed [31:0] neuron;

  always_comb begin
    if (layer && acc > ACC2_MAX) begin
      acc_op = 43'(ACC2_MAX);
    end else if (layer && acc < ACC2_MIN) begin
      acc_op = 43'(ACC2_MIN);
    end else begin
      acc_op = 43'(acc);
    end
    msh = layer ? (mprod >>> 16) : (mprod >>> 8);
    tot = 65'(msh) + 65'(bprod);
    if (tot > I32_MAX) begin
      neuron = 32'(I32_MAX);
    end else if (tot < I32_MIN) begin
      neuron = 32'(I32_MIN);
    end else begin
      neuron = 32'(tot);
    end
    if (!layer && neuron < 0) begin
      neuron = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCALE) begin
      mprod <= acc_op * signed'({1'b0, (layer ? l2_wscale : l1_wscale)});
      bprod <= (layer ? b2_rd : b1_rd) * signed'({1'b0, (layer ? l2_bscale : l1_bscale)});
    end
    if (state == S_STORE) begin
      if (layer) begin
        lgt_mem[j[C_W-1:0]] <= neuron;
      end else begin
        hid_mem[j[H_W-1:0]] <= neuron;
      end
    end
  end

  // Softmax: maximum pass, then exp table pass with a running sum.
  logic               max_v, max_first, exp_v;
  logic [C_W-1:0]     exp_k;
  logic signed [31:0] mx;
  logic signed [32:0] lgap;
  logic [7:0]         tab_idx;
  logic [EXP_W-1:0]   e_val;
  logic [SUM_W-1:0]   sum;

  always_comb begin
    lgap    = 33'(mx) - 33'(lgt_rd);
    tab_idx = (lgap[32:20] != '0) ? 8'hFF : lgap[19:12];
    e_val   = EXP_TABLE[tab_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_v <= 1'b0;
      exp_v <= 1'b0;
    end else begin
      max_v <= (state == S_MAX);
      exp_v <= (state == S_EXP);
    end
  end

  always_ff @(posedge clk) begin
    max_first <= (k == '0);
    exp_k     <= k;
    if (max_v && (max_first || lgt_rd > mx)) begin
      mx <= lgt_rd;
    end
    if (exp_v) begin
      e_mem[exp_k] <= e_val;
      sum <= (exp_k == '0) ? SUM_W'(e_val) : sum + SUM_W'(e_val);
    end
  end

  // Division by the sum and the running argmax.
  logic              div_done;
  logic [EXP_W-1:0]  div_quo;
  logic [PROB_W-1:0] prob, pbest;
  logic [C_W-1:0]    best;

  imlp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .num   (e_rd),
    .den   (sum),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign prob = (sum == '0) ? '0 : (div_quo[EXP_W-1] ? '1 : div_quo[PROB_W-1:0]);

  always_ff @(posedge clk) begin
    if (state == S_DIV_WAIT && div_done) begin
      p_mem[k] <= prob;
      if (k == '0 || prob > pbest) begin
        best  <= k;
        pbest <= prob;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == S_OUT_LD) begin
      out_data.class_index <= 6'(k);
      out_data.probability <= p_rd;
      out_data.best_class  <= 6'(best);
      out_data.last        <= k_last;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fc        <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      layer     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && in_data.func == FUNC_FEATURE) begin
            if (fc == FC_W'(FEATURES - 1)) begin
              fc    <= '0;
              i     <= '0;
              j     <= '0;
              layer <= 1'b0;
              state <= S_RUN;
            end else begin
              fc <= fc + 1'b1;
            end
          end
        end
        S_RUN: begin
          if (i_last) begin
            i     <= '0;
            state <= S_DRAIN;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_DRAIN: begin
          if (acc_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_STORE;
        end
        S_STORE: begin
          if (j_last) begin
            j <= '0;
            if (layer) begin
              k     <= '0;
              state <= S_MAX;
            end else begin
              layer <= 1'b1;
              state <= S_RUN;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_RUN;
          end
        end
        S_MAX: begin
          if (k_last) begin
            k     <= '0;
            state <= S_EXP;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_EXP: begin
          if (k_last) begin
            k     <= '0;
            state <= S_DIV_RD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DIV_RD: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (k_last) begin
              k     <= '0;
              state <= S_OUT_RD;
            end else begin
              k     <= k + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (k_last) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/imlp_div.sv
module imlp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [imlp_pkg::EXP_W-1:0]  num,
  input  logic [imlp_pkg::SUM_W-1:0]  den,
  output logic                        done,
  output logic [imlp_pkg::EXP_W-1:0]  quo
);
  import imlp_pkg::*;

  // Restoring divider for (num * 2^16) / den, one quotient bit per cycle.
  // The quotient never exceeds 2^16 because num is at most den.
  localparam int STEPS = EXP_W;
  localparam int CNT_W = $clog2(STEPS);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W:0]     rem;
  logic [SUM_W-1:0]   dvs;
  logic [SUM_W:0]     trial;
  logic               qbit;

  // The first step uses the numerator as is; later steps shift in a zero.
  always_comb begin
    trial = (cnt == '0) ? rem : {rem[SUM_W-1:0], 1'b0};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= (SUM_W+1)'(num);
        dvs  <= den;
        quo  <= '0;
      end else if (busy) begin
        rem <= qbit ? (trial - {1'b0, dvs}) : trial;
        quo <= {quo[EXP_W-2:0], qbit};
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule
